[rtl/element_unit_normal_unit_defines.svh]
// Assertion macros used by the checker file of the element unit normal block.
`ifndef ELEMENT_UNIT_NORMAL_UNIT_DEFINES_SVH
`define ELEMENT_UNIT_NORMAL_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define EUN_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define EUN_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/eun_pkg.sv]
// Package: widths, codes and shared types of the element unit normal block.
package eun_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int DIFF_W      = COORD_WIDTH + 1;
   localparam int PROD_W      = 2 * DIFF_W;
   localparam int CROSS_W     = PROD_W + 1;
   localparam int MAG_W       = PROD_W;
   localparam int LEAD_W      = $clog2(MAG_W);
   localparam int NORM_TOP    = 29;
   localparam int NORM_W      = NORM_TOP + 1;
   localparam int SQ_W        = 2 * NORM_W;
   localparam int SUM_W       = SQ_W + 2;
   localparam int TRIAL_W     = SUM_W + 2;
   localparam int ROOT_W      = SUM_W / 2;
   localparam int FRAC_BITS   = 14;
   localparam int QUO_W       = FRAC_BITS + 1;
   localparam int NUM_W       = NORM_W + FRAC_BITS + 1;
   localparam int COMP_W      = 16;
   localparam int INDEX_W     = 24;

   localparam logic [QUO_W-1:0]         ONE_Q     = QUO_W'(2 ** FRAC_BITS);
   localparam logic signed [COMP_W-1:0] ONE_N     = COMP_W'(2 ** FRAC_BITS);
   localparam logic signed [COMP_W-1:0] NEG_ONE_N = -ONE_N;

   // element types
   localparam logic [1:0] FUNC_VERTEX = 2'd0;
   localparam logic [1:0] FUNC_LINE   = 2'd1;
   localparam logic [1:0] FUNC_TRI    = 2'd2;
   localparam logic [1:0] FUNC_UNSUP  = 2'd3;

   // status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_ZERO  = 2'd1;
   localparam logic [1:0] STAT_UNSUP = 2'd2;
   localparam logic [1:0] STAT_COUNT = 2'd3;

   localparam logic [3:0] LINE_POINTS = 4'd2;
   localparam logic [3:0] TRI_POINTS  = 4'd3;

   // side information that rides along the pipeline
   typedef struct packed {
      logic               live;
      logic               line;
      logic [1:0]         status;
      logic [2:0]         neg;
      logic [INDEX_W-1:0] index;
   } side_type;

   typedef logic [2:0][NORM_W-1:0] nvec_type;
   typedef logic [2:0][NUM_W-1:0]  nrem_type;
   typedef logic [2:0][QUO_W-1:0]  quo_type;

endpackage

[rtl/element_unit_normal_unit.sv]
// Top level: pipelined unit normal of one mesh element per transaction.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_valid/req_stall  | func, point_count, p0..p2 xyz, elem_index
//   rsp     | out | rsp_valid/rsp_stall  | nx, ny, nz, status, out_index
//
// One transaction per cycle while req_stall is low; 7 front stages (differences,
// products, cross, magnitude, leading one, normalize, squares), 32 square root
// stages (sum of squares, then one root bit each), 16 divide stages (rounded
// numerators, then one quotient bit each), output.
// Synchronous reset clears all valid bits; payload registers are not reset.
// A one-entry skid behind the output register takes a transaction while a
// result waits; the pipeline freezes only when the skid is full.
module element_unit_normal_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [1:0]                              req_func,
   input  logic [3:0]                              req_point_count,
   input  logic signed [eun_pkg::COORD_WIDTH-1:0]  req_p0x,
   input  logic signed [eun_pkg::COORD_WIDTH-1:0]  req_p0y,
   input  logic signed [eun_pkg::COORD_WIDTH-1:0]  req_p0z,
   input  logic signed [eun_pkg::COORD_WIDTH-1:0]  req_p1x,
   input  logic signed [eun_pkg::COORD_WIDTH-1:0]  req_p1y,
   input  logic signed [eun_pkg::COORD_WIDTH-1:0]  req_p1z,
   input  logic signed [eun_pkg::COORD_WIDTH-1:0]  req_p2x,
   input  logic signed [eun_pkg::COORD_WIDTH-1:0]  req_p2y,
   input  logic signed [eun_pkg::COORD_WIDTH-1:0]  req_p2z,
   input  logic [eun_pkg::INDEX_W-1:0]             req_elem_index,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [eun_pkg::COMP_W-1:0]       rsp_nx,
   output logic signed [eun_pkg::COMP_W-1:0]       rsp_ny,
   output logic signed [eun_pkg::COMP_W-1:0]       rsp_nz,
   output logic [1:0]                              rsp_status,
   output logic [eun_pkg::INDEX_W-1:0]             rsp_out_index
);
   import eun_pkg::*;

   typedef struct packed {
      logic signed [COMP_W-1:0] nx;
      logic signed [COMP_W-1:0] ny;
      logic signed [COMP_W-1:0] nz;
      logic [1:0]               status;
      logic [INDEX_W-1:0]       index;
   } rsp_type;

   logic en;

   // front stages
   logic                      s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, s6_v_ff, s7_v_ff;
   logic signed [DIFF_W-1:0]  s1_a_in [3];
   logic signed [DIFF_W-1:0]  s1_b_in [3];
   logic signed [DIFF_W-1:0]  s1_a_ff [3];
   logic signed [DIFF_W-1:0]  s1_b_ff [3];
   side_type                  s1_side_in, s1_side_ff;
   logic signed [PROD_W-1:0]  s2_pr_in [6];
   logic signed [PROD_W-1:0]  s2_pr_ff [6];
   side_type                  s2_side_ff;
   logic signed [CROSS_W-1:0] s3_c_in [3];
   logic signed [CROSS_W-1:0] s3_c_ff [3];
   side_type                  s3_side_ff;
   logic [MAG_W-1:0]          s4_mag_in [3];
   logic [MAG_W-1:0]          s4_mag_ff [3];
   side_type                  s4_side_in, s4_side_ff;
   logic [MAG_W-1:0]          s5_mag_ff [3];
   logic [LEAD_W-1:0]         s5_lead_in, s5_lead_ff;
   side_type                  s5_side_in, s5_side_ff;
   nvec_type                  s6_a_in, s6_a_ff;
   side_type                  s6_side_ff;
   logic [SQ_W-1:0]           s7_sq_in [3];
   logic [SQ_W-1:0]           s7_sq_ff [3];
   nvec_type                  s7_a_ff;
   side_type                  s7_side_ff;

   // square root stages
   logic                      sr_v_ff    [ROOT_W+1];
   logic [SUM_W-1:0]          sr_rem_in  [ROOT_W+1];
   logic [SUM_W-1:0]          sr_rem_ff  [ROOT_W+1];
   logic [ROOT_W-1:0]         sr_root_in [ROOT_W+1];
   logic [ROOT_W-1:0]         sr_root_ff [ROOT_W+1];
   nvec_type                  sr_a_in    [ROOT_W+1];
   nvec_type                  sr_a_ff    [ROOT_W+1];
   side_type                  sr_side_in [ROOT_W+1];
   side_type                  sr_side_ff [ROOT_W+1];

   // divide stages
   logic                      dv_v_ff    [QUO_W+1];
   nrem_type                  dv_rem_in  [QUO_W+1];
   nrem_type                  dv_rem_ff  [QUO_W+1];
   quo_type                   dv_q_in    [QUO_W+1];
   quo_type                   dv_q_ff    [QUO_W+1];
   logic [ROOT_W-1:0]         dv_len_in  [QUO_W+1];
   logic [ROOT_W-1:0]         dv_len_ff  [QUO_W+1];
   side_type                  dv_side_in [QUO_W+1];
   side_type                  dv_side_ff [QUO_W+1];

   // output register and skid
   rsp_type fin;
   rsp_type out_in, out_ff, skid_in, skid_ff;
   logic    out_v_in, out_v_ff, skid_v_in, skid_v_ff;
   logic    inc, out_take;

   assign en        = !skid_v_ff;
   assign req_stall = skid_v_ff;

   // stage 1: checks and edge vectors
   always_comb begin
      s1_side_in        = '0;
      s1_side_in.index  = req_elem_index;
      s1_side_in.status = STAT_OK;
      s1_side_in.line   = (req_func == FUNC_LINE);
      case (req_func)
         FUNC_LINE: begin
            if (req_point_count != LINE_POINTS) s1_side_in.status = STAT_COUNT;
            else s1_side_in.live = 1'b1;
         end
         FUNC_TRI: begin
            if (req_point_count != TRI_POINTS) s1_side_in.status = STAT_COUNT;
            else s1_side_in.live = 1'b1;
         end
         FUNC_UNSUP: s1_side_in.status = STAT_UNSUP;
         default: ;
      endcase
      if (req_func == FUNC_TRI) begin
         s1_a_in[0] = DIFF_W'(req_p1x) - DIFF_W'(req_p0x);
         s1_a_in[1] = DIFF_W'(req_p1y) - DIFF_W'(req_p0y);
         s1_a_in[2] = DIFF_W'(req_p1z) - DIFF_W'(req_p0z);
         s1_b_in[0] = DIFF_W'(req_p2x) - DIFF_W'(req_p0x);
         s1_b_in[1] = DIFF_W'(req_p2y) - DIFF_W'(req_p0y);
         s1_b_in[2] = DIFF_W'(req_p2z) - DIFF_W'(req_p0z);
      end else begin
         // line: rotated direction (dy, -dx, -dz)
         s1_a_in[0] = DIFF_W'(req_p1y) - DIFF_W'(req_p0y);
         s1_a_in[1] = DIFF_W'(req_p0x) - DIFF_W'(req_p1x);
         s1_a_in[2] = DIFF_W'(req_p0z) - DIFF_W'(req_p1z);
         s1_b_in[0] = '0;
         s1_b_in[1] = '0;
         s1_b_in[2] = '0;
      end
   end

   // stage 2: cross product terms; a line passes through the even slots
   always_comb begin
      if (s1_side_ff.line) begin
         s2_pr_in[0] = PROD_W'(s1_a_ff[0]);
         s2_pr_in[1] = '0;
         s2_pr_in[2] = PROD_W'(s1_a_ff[1]);
         s2_pr_in[3] = '0;
         s2_pr_in[4] = PROD_W'(s1_a_ff[2]);
         s2_pr_in[5] = '0;
      end else begin
         s2_pr_in[0] = s1_a_ff[1] * s1_b_ff[2];
         s2_pr_in[1] = s1_a_ff[2] * s1_b_ff[1];
         s2_pr_in[2] = s1_a_ff[2] * s1_b_ff[0];
         s2_pr_in[3] = s1_a_ff[0] * s1_b_ff[2];
         s2_pr_in[4] = s1_a_ff[0] * s1_b_ff[1];
         s2_pr_in[5] = s1_a_ff[1] * s1_b_ff[0];
      end
   end

   // stage 3: cross differences
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s3_c_in[i] = CROSS_W'(s2_pr_ff[2*i]) - CROSS_W'(s2_pr_ff[2*i+1]);
      end
   end

   // stage 4: sign and magnitude
   always_comb begin
      s4_side_in = s3_side_ff;
      for (int i = 0; i < 3; i++) begin
         s4_side_in.neg[i] = s3_c_ff[i][CROSS_W-1];
         s4_mag_in[i] = s3_c_ff[i][CROSS_W-1] ? MAG_W'(-s3_c_ff[i]) : MAG_W'(s3_c_ff[i]);
      end
   end

   // stage 5: leading one of the largest magnitude, zero-length check
   always_comb begin
      logic [MAG_W-1:0] or_m;
      or_m = s4_mag_ff[0] | s4_mag_ff[1] | s4_mag_ff[2];
      s5_lead_in = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (or_m[i]) s5_lead_in = LEAD_W'(i);
      end
      s5_side_in = s4_side_ff;
      if (s4_side_ff.live && or_m == '0) begin
         s5_side_in.live   = 1'b0;
         s5_side_in.status = STAT_ZERO;
      end
   end

   // stage 6: block scale so the top bit lands on NORM_TOP
   always_comb begin
      logic [LEAD_W-1:0] sh;
      sh = '0;
      for (int i = 0; i < 3; i++) begin
         if (s5_lead_ff >= LEAD_W'(NORM_TOP)) begin
            sh = s5_lead_ff - LEAD_W'(NORM_TOP);
            s6_a_in[i] = NORM_W'(s5_mag_ff[i] >> sh);
         end else begin
            sh = LEAD_W'(NORM_TOP) - s5_lead_ff;
            s6_a_in[i] = NORM_W'(s5_mag_ff[i] << sh);
         end
      end
   end

   // stage 7: squares
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s7_sq_in[i] = SQ_W'(s6_a_ff[i]) * SQ_W'(s6_a_ff[i]);
      end
   end

   // square root entry: sum of squares
   always_comb begin
      sr_rem_in[0]  = SUM_W'(s7_sq_ff[0]) + SUM_W'(s7_sq_ff[1]) + SUM_W'(s7_sq_ff[2]);
      sr_root_in[0] = '0;
      sr_a_in[0]    = s7_a_ff;
      sr_side_in[0] = s7_side_ff;
   end

   // square root: one root bit per stage, remainder form
   for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
      localparam int K = ROOT_W - 1 - j;
      logic [TRIAL_W-1:0] trial;
      logic               take;
      assign trial = (TRIAL_W'(sr_root_ff[j]) << (K + 1)) | (TRIAL_W'(1) << (2 * K));
      assign take  = TRIAL_W'(sr_rem_ff[j]) >= trial;
      always_comb begin
         sr_rem_in[j+1]  = sr_rem_ff[j];
         sr_root_in[j+1] = sr_root_ff[j];
         if (take) begin
            sr_rem_in[j+1]  = sr_rem_ff[j] - trial[SUM_W-1:0];
            sr_root_in[j+1] = sr_root_ff[j] | (ROOT_W'(1) << K);
         end
         sr_a_in[j+1]    = sr_a_ff[j];
         sr_side_in[j+1] = sr_side_ff[j];
      end
   end

   // divide entry: rounded numerators over the length
   always_comb begin
      dv_len_in[0]  = sr_root_ff[ROOT_W];
      dv_q_in[0]    = '0;
      dv_side_in[0] = sr_side_ff[ROOT_W];
      for (int c = 0; c < 3; c++) begin
         dv_rem_in[0][c] = (NUM_W'(sr_a_ff[ROOT_W][c]) << FRAC_BITS)
                           + NUM_W'(sr_root_ff[ROOT_W] >> 1);
      end
   end

   // restoring divide: one quotient bit per stage, three lanes
   for (genvar j = 0; j < QUO_W; j++) begin : g_div
      localparam int K = QUO_W - 1 - j;
      logic [NUM_W-1:0] sub;
      assign sub = NUM_W'(dv_len_ff[j]) << K;
      always_comb begin
         dv_rem_in[j+1] = dv_rem_ff[j];
         dv_q_in[j+1]   = dv_q_ff[j];
         for (int c = 0; c < 3; c++) begin
            if (dv_rem_ff[j][c] >= sub) begin
               dv_rem_in[j+1][c]  = dv_rem_ff[j][c] - sub;
               dv_q_in[j+1][c][K] = 1'b1;
            end
         end
         dv_len_in[j+1]  = dv_len_ff[j];
         dv_side_in[j+1] = dv_side_ff[j];
      end
   end

   // final: clamp, sign, zero on any fault
   always_comb begin
      logic [QUO_W-1:0]         qc;
      logic signed [COMP_W-1:0] n [3];
      for (int c = 0; c < 3; c++) begin
         qc = (dv_q_ff[QUO_W][c] > ONE_Q) ? ONE_Q : dv_q_ff[QUO_W][c];
         if (!dv_side_ff[QUO_W].live) n[c] = '0;
         else if (dv_side_ff[QUO_W].neg[c]) n[c] = -COMP_W'(qc);
         else n[c] = COMP_W'(qc);
      end
      fin.nx     = n[0];
      fin.ny     = n[1];
      fin.nz     = n[2];
      fin.status = dv_side_ff[QUO_W].status;
      fin.index  = dv_side_ff[QUO_W].index;
   end

   // output register with one-entry skid
   assign inc      = en && dv_v_ff[QUO_W];
   assign out_take = out_v_ff && !rsp_stall;

   always_comb begin
      out_v_in  = out_v_ff;
      skid_v_in = skid_v_ff;
      out_in    = out_ff;
      skid_in   = skid_ff;
      if (skid_v_ff) begin
         if (out_take) begin
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (inc) begin
         if (!out_v_ff || out_take) begin
            out_in   = fin;
            out_v_in = 1'b1;
         end else begin
            skid_in   = fin;
            skid_v_in = 1'b1;
         end
      end else if (out_take) begin
         out_v_in = 1'b0;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
         s3_v_ff   <= 1'b0;
         s4_v_ff   <= 1'b0;
         s5_v_ff   <= 1'b0;
         s6_v_ff   <= 1'b0;
         s7_v_ff   <= 1'b0;
         sr_v_ff   <= '{default: 1'b0};
         dv_v_ff   <= '{default: 1'b0};
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (en) begin
            s1_v_ff    <= req_valid;
            s2_v_ff    <= s1_v_ff;
            s3_v_ff    <= s2_v_ff;
            s4_v_ff    <= s3_v_ff;
            s5_v_ff    <= s4_v_ff;
            s6_v_ff    <= s5_v_ff;
            s7_v_ff    <= s6_v_ff;
            sr_v_ff[0] <= s7_v_ff;
            for (int j = 0; j < ROOT_W; j++) sr_v_ff[j+1] <= sr_v_ff[j];
            dv_v_ff[0] <= sr_v_ff[ROOT_W];
            for (int j = 0; j < QUO_W; j++) dv_v_ff[j+1] <= dv_v_ff[j];
         end
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (en) begin
         s1_a_ff    <= s1_a_in;
         s1_b_ff    <= s1_b_in;
         s1_side_ff <= s1_side_in;
         s2_pr_ff   <= s2_pr_in;
         s2_side_ff <= s1_side_ff;
         s3_c_ff    <= s3_c_in;
         s3_side_ff <= s2_side_ff;
         s4_mag_ff  <= s4_mag_in;
         s4_side_ff <= s4_side_in;
         s5_mag_ff  <= s4_mag_ff;
         s5_lead_ff <= s5_lead_in;
         s5_side_ff <= s5_side_in;
         s6_a_ff    <= s6_a_in;
         s6_side_ff <= s5_side_ff;
         s7_sq_ff   <= s7_sq_in;
         s7_a_ff    <= s6_a_ff;
         s7_side_ff <= s6_side_ff;
         sr_rem_ff  <= sr_rem_in;
         sr_root_ff <= sr_root_in;
         sr_a_ff    <= sr_a_in;
         sr_side_ff <= sr_side_in;
         dv_rem_ff  <= dv_rem_in;
         dv_q_ff    <= dv_q_in;
         dv_len_ff  <= dv_len_in;
         dv_side_ff <= dv_side_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_nx        = out_ff.nx;
   assign rsp_ny        = out_ff.ny;
   assign rsp_nz        = out_ff.nz;
   assign rsp_status    = out_ff.status;
   assign rsp_out_index = out_ff.index;

endmodule

[rtl/eun_checker.sv]
// Port-level checker for the element unit normal block, bound to the top level.
`include "element_unit_normal_unit_defines.svh"

module eun_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    rsp_valid,
   input logic                                    rsp_stall,
   input logic signed [eun_pkg::COMP_W-1:0]       rsp_nx,
   input logic signed [eun_pkg::COMP_W-1:0]       rsp_ny,
   input logic signed [eun_pkg::COMP_W-1:0]       rsp_nz,
   input logic [1:0]                              rsp_status,
   input logic [eun_pkg::INDEX_W-1:0]             rsp_out_index
);
   import eun_pkg::*;

   // a faulted transaction carries a zero normal
   `EUN_ASSERT_IMPL(a_fault_zero, rsp_valid && rsp_status != STAT_OK, rsp_nx == '0 && rsp_ny == '0 && rsp_nz == '0, "fault with nonzero normal")

   // every component stays within plus or minus one
   `EUN_ASSERT_IMPL(a_range, rsp_valid, rsp_nx <= ONE_N && rsp_nx >= NEG_ONE_N && rsp_ny <= ONE_N && rsp_ny >= NEG_ONE_N && rsp_nz <= ONE_N && rsp_nz >= NEG_ONE_N, "normal component out of range")

   // a stalled result holds
   `EUN_ASSERT_NEXT(a_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_nx) && $stable(rsp_ny) && $stable(rsp_nz) && $stable(rsp_status) && $stable(rsp_out_index), "stalled result changed")

   // nothing comes out right after reset
   `EUN_ASSERT_IMPL(a_reset_empty, $fell(reset), !rsp_valid, "result valid right after reset")

endmodule

bind element_unit_normal_unit eun_checker u_eun_checker (.*);

[bench/element_unit_normal_unit_tb.sv]
// Testbench for the element unit normal block: random and directed elements, predicted normals.
module element_unit_normal_unit_tb;
   import eun_pkg::*;

   localparam int CW         = COORD_WIDTH;
   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_WAIT = 120;
   localparam int RAND_ITEMS = 1600;

   typedef struct {
      logic [1:0]           func;
      logic [3:0]           count;
      logic signed [CW-1:0] p[9];
      logic [INDEX_W-1:0]   index;
   } elem_type;

   typedef struct {
      logic signed [COMP_W-1:0] n[3];
      logic [1:0]               status;
      logic [INDEX_W-1:0]       index;
   } normal_type;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   logic [1:0] req_func, rsp_status;
   logic [3:0] req_point_count;
   logic signed [CW-1:0] req_p[9];
   logic [INDEX_W-1:0] req_elem_index, rsp_out_index;
   logic signed [COMP_W-1:0] rsp_nx, rsp_ny, rsp_nz;

   elem_type   pending_elems[$];
   normal_type expected_normals[$];
   int  error_count = 0;
   int  send_gap = 0, sent_count = 0, drain_at = 0, idle_cycles = 0, stall_left = 0;
   bit  calm = 0, drained = 0;

   element_unit_normal_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_func(req_func), .req_point_count(req_point_count),
      .req_p0x(req_p[0]), .req_p0y(req_p[1]), .req_p0z(req_p[2]),
      .req_p1x(req_p[3]), .req_p1y(req_p[4]), .req_p1z(req_p[5]),
      .req_p2x(req_p[6]), .req_p2y(req_p[7]), .req_p2z(req_p[8]),
      .req_elem_index(req_elem_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_nx(rsp_nx), .rsp_ny(rsp_ny), .rsp_nz(rsp_nz),
      .rsp_status(rsp_status), .rsp_out_index(rsp_out_index)
   );

   // ---------------- predictor ----------------
   function automatic longint unsigned magnitude(longint v);
      return v < 0 ? longint'(0) - v : v;
   endfunction

   // right shift every entry toward zero until all magnitudes fit below 2^30
   function automatic void fit_below_top(inout longint v[6], input int n);
      longint unsigned m;
      int s;
      m = 0;
      s = 0;
      for (int i = 0; i < n; i++)
         if (magnitude(v[i]) > m) m = magnitude(v[i]);
      while ((m >> s) >= (64'd1 << 30)) s++;
      for (int i = 0; i < n; i++)
         v[i] = v[i] < 0 ? -longint'(magnitude(v[i]) >> s) : longint'(magnitude(v[i]) >> s);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic normal_type predict_normal(elem_type e);
      normal_type r;
      longint p[9], d[6], c[6];
      longint unsigned m, sum, len, a, q;
      int s;
      bit build;
      build = 0;
      r.status = STAT_OK;
      r.index = e.index;
      for (int i = 0; i < 3; i++) r.n[i] = '0;
      for (int i = 0; i < 9; i++) p[i] = e.p[i];
      for (int i = 0; i < 6; i++) c[i] = 0;
      if (e.func == FUNC_UNSUP) begin
         r.status = STAT_UNSUP;
      end else if (e.func == FUNC_LINE) begin
         if (e.count != LINE_POINTS) begin
            r.status = STAT_COUNT;
         end else begin
            c[0] = -(p[1] - p[4]);
            c[1] = p[0] - p[3];
            c[2] = p[2] - p[5];
            build = 1;
         end
      end else if (e.func == FUNC_TRI) begin
         if (e.count != TRI_POINTS) begin
            r.status = STAT_COUNT;
         end else begin
            for (int i = 0; i < 3; i++) begin
               d[i]     = p[3+i] - p[i];
               d[3+i]   = p[6+i] - p[i];
            end
            fit_below_top(d, 6);
            c[0] = d[1] * d[5] - d[2] * d[4];
            c[1] = d[2] * d[3] - d[0] * d[5];
            c[2] = d[0] * d[4] - d[1] * d[3];
            build = 1;
         end
      end
      // normalize: block scale to [2^29, 2^30), then divide by the length
      if (build) begin
         fit_below_top(c, 3);
         m = 0;
         for (int i = 0; i < 3; i++)
            if (magnitude(c[i]) > m) m = magnitude(c[i]);
         if (m == 0) begin
            r.status = STAT_ZERO;
         end else begin
            s = 0;
            sum = 0;
            while ((m << s) < (64'd1 << 29)) s++;
            for (int i = 0; i < 3; i++) begin
               a = magnitude(c[i]) << s;
               sum += a * a;
            end
            len = int_sqrt(sum);
            for (int i = 0; i < 3; i++) begin
               a = magnitude(c[i]) << s;
               q = (a * 16384 + len / 2) / len;
               if (q > 16384) q = 16384;
               r.n[i] = c[i] < 0 ? -COMP_W'(q) : COMP_W'(q);
            end
         end
      end
      return r;
   endfunction

   // ---------------- stimulus ----------------
   task automatic add_pending(elem_type e);
      pending_elems.insert(pending_elems.size(), e);
   endtask

   function automatic logic signed [CW-1:0] random_coord(int span);
      case ($urandom_range(0, 9))
         0:       return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
         1, 2:    return CW'($urandom);
         default: return CW'(int'($urandom_range(0, 2 * span)) - span);
      endcase
   endfunction

   function automatic elem_type random_elem();
      elem_type e;
      int span, k;
      span = 1 << $urandom_range(1, 23);
      e.func = $urandom_range(0, 9) < 1 ? 2'($urandom) :
               ($urandom_range(0, 2) == 0 ? FUNC_LINE : FUNC_TRI);
      e.count = e.func == FUNC_LINE ? LINE_POINTS : TRI_POINTS;
      if ($urandom_range(0, 9) == 0) e.count = 4'($urandom);
      for (int i = 0; i < 9; i++) e.p[i] = random_coord(span);
      e.index = INDEX_W'($urandom);
      // occasional degenerate geometry: repeated or collinear points
      case ($urandom_range(0, 15))
         0: for (int i = 0; i < 3; i++) e.p[3+i] = e.p[i];
         1: begin
            k = $urandom_range(0, 3) - 1;
            for (int i = 0; i < 3; i++) begin
               e.p[i]   = CW'(int'($urandom_range(0, 2000)) - 1000);
               e.p[3+i] = CW'(int'($urandom_range(0, 2000)) - 1000);
               e.p[6+i] = CW'(e.p[i] + k * (e.p[3+i] - e.p[i]));
            end
         end
         default: ;
      endcase
      return e;
   endfunction

   function automatic elem_type make_elem(logic [1:0] f, logic [3:0] n, int a, int b, int c);
      elem_type e;
      e.func = f;
      e.count = n;
      for (int i = 0; i < 3; i++) begin
         e.p[i] = CW'(a);
         e.p[3+i] = CW'(b);
         e.p[6+i] = CW'(c);
      end
      e.p[4] = CW'(b + 4096);
      e.p[8] = CW'(c - 8192);
      e.index = INDEX_W'($urandom);
      return e;
   endfunction

   function automatic int next_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (calm || pick < 65) return 0;
      if (pick < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // length of one output stall burst: mostly short, a few long
   function automatic int next_stall();
      if ($urandom_range(0, 99) < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // ---------------- clock and reset ----------------
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1;
      repeat (10) @(posedge clock);
      reset <= 0;
   end

   // ---------------- driver ----------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
         rsp_stall <= 0;
      end else begin
         if ($urandom_range(0, 99) == 0) calm <= ~calm;
         // output stalls come in bursts
         if (stall_left > 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else if (!calm && $urandom_range(0, 99) < 25) begin
            rsp_stall  <= 1'b1;
            stall_left <= next_stall() - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 0;
            end else if (sent_count == drain_at && !drained &&
                         (expected_normals.size() != 0 || (req_valid && !req_stall))) begin
               // hold off until the pipeline has emptied
               req_valid <= 0;
            end else if (pending_elems.size() != 0) begin
               elem_type e;
               e = pending_elems.pop_front();
               if (sent_count == drain_at) drained <= 1;
               req_valid       <= 1;
               req_func        <= e.func;
               req_point_count <= e.count;
               for (int i = 0; i < 9; i++) req_p[i] <= e.p[i];
               req_elem_index  <= e.index;
               sent_count      <= sent_count + 1;
               send_gap        <= next_gap();
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // ---------------- monitor ----------------
   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            elem_type e;
            e.func = req_func;
            e.count = req_point_count;
            for (int i = 0; i < 9; i++) e.p[i] = req_p[i];
            e.index = req_elem_index;
            expected_normals.insert(expected_normals.size(), predict_normal(e));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_normals.size() == 0) begin
               report_mismatch("unexpected transaction, index", rsp_out_index, -1);
            end else begin
               normal_type x;
               x = expected_normals.pop_front();
               if (rsp_nx != x.n[0]) report_mismatch("nx", rsp_nx, x.n[0]);
               if (rsp_ny != x.n[1]) report_mismatch("ny", rsp_ny, x.n[1]);
               if (rsp_nz != x.n[2]) report_mismatch("nz", rsp_nz, x.n[2]);
               if (rsp_status != x.status) report_mismatch("status", rsp_status, x.status);
               if (rsp_out_index != x.index)
                  report_mismatch("out_index", rsp_out_index, x.index);
            end
         end
      end
   end

   // watchdog: cycles with no transaction on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // ---------------- sequence ----------------
   initial begin
      req_func = '0;
      req_point_count = '0;
      req_elem_index = '0;
      for (int i = 0; i < 9; i++) req_p[i] = '0;
      req_valid = 0;
      rsp_stall = 0;
      drain_at = RAND_ITEMS / 2;

      // directed: each type, count errors, degenerate and extreme geometry
      add_pending(make_elem(FUNC_VERTEX, 4'd0, 5, -7, 9));
      add_pending(make_elem(FUNC_VERTEX, 4'd15, 0, 0, 0));
      add_pending(make_elem(FUNC_UNSUP, 4'd3, 100, 200, 300));
      add_pending(make_elem(FUNC_LINE, LINE_POINTS, 0, 4096, 0));
      add_pending(make_elem(FUNC_LINE, 4'd3, 0, 4096, 0));
      add_pending(make_elem(FUNC_TRI, TRI_POINTS, 0, 4096, 12288));
      add_pending(make_elem(FUNC_TRI, 4'd2, 0, 4096, 12288));
      add_pending(make_elem(FUNC_TRI, 4'd15, 0, 4096, 12288));
      begin
         elem_type e;
         // coincident line points
         e = make_elem(FUNC_LINE, LINE_POINTS, 77, 77, 0);
         e.p[4] = e.p[1];
         add_pending(e);
         // collinear triangle
         e = make_elem(FUNC_TRI, TRI_POINTS, 0, 0, 0);
         for (int i = 0; i < 3; i++) begin
            e.p[3+i] = CW'(i + 1);
            e.p[6+i] = CW'(2 * (i + 1));
         end
         add_pending(e);
         // triangle whose third point repeats the first
         e = make_elem(FUNC_TRI, TRI_POINTS, 300, -500, 0);
         for (int i = 0; i < 3; i++) e.p[6+i] = e.p[i];
         add_pending(e);
         // corner coordinates at both extremes
         for (int f = 1; f <= 2; f++) begin
            e = make_elem(2'(f), f == 1 ? LINE_POINTS : TRI_POINTS, 0, 0, 0);
            for (int i = 0; i < 9; i++)
               e.p[i] = ((i + f) % 2) ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            e.p[7] = '0;
            e.index = '1;
            add_pending(e);
         end
         e = make_elem(FUNC_TRI, TRI_POINTS, -8388608, 8388607, -8388608);
         e.index = '0;
         add_pending(e);
         // single-unit differences: smallest nonzero vectors
         e = make_elem(FUNC_LINE, LINE_POINTS, 0, 0, 0);
         e.p[4] = 0;
         e.p[5] = 1;
         add_pending(e);
      end
      for (int i = 0; i < RAND_ITEMS; i++) add_pending(random_elem());

      @(negedge reset);
      wait (pending_elems.size() == 0 && !req_valid);
      @(posedge clock);
      wait (expected_normals.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0 && expected_normals.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/eun_pkg.sv
rtl/element_unit_normal_unit.sv
rtl/eun_checker.sv
bench/element_unit_normal_unit_tb.sv
